// ----- design/aavd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// aavd_pkg: shared types and constants for the averaging voltmeter
// Segment table, decimal split of the displayed value, divider status.
// ----------------------------------------------------------------------------
package aavd_pkg;

    localparam int VOLT_W = 6;
    localparam int SEG_W  = 7;
    localparam int EN_W   = 2;
    localparam int CNT_W  = 4;

    localparam logic [CNT_W-1:0] CNT_RESET = 4'd7;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    localparam logic [EN_W-1:0] EN_NONE = 2'b00;
    localparam logic [EN_W-1:0] EN_LOW  = 2'b01;
    localparam logic [EN_W-1:0] EN_HIGH = 2'b10;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    // hex digit to segment pattern, bit0 = a .. bit6 = g
    function automatic logic [SEG_W-1:0] seg_lookup(input logic [3:0] digit);
        logic [SEG_W-1:0] pat;
        begin
            case (digit)
                4'h0: pat = 7'h3F;
                4'h1: pat = 7'h06;
                4'h2: pat = 7'h5B;
                4'h3: pat = 7'h4F;
                4'h4: pat = 7'h66;
                4'h5: pat = 7'h6D;
                4'h6: pat = 7'h7D;
                4'h7: pat = 7'h07;
                4'h8: pat = 7'h7F;
                4'h9: pat = 7'h6F;
                4'hA: pat = 7'h77;
                4'hB: pat = 7'h7C;
                4'hC: pat = 7'h39;
                4'hD: pat = 7'h5E;
                4'hE: pat = 7'h79;
                4'hF: pat = 7'h71;
                default: pat = 7'h00;
            endcase
            return pat;
        end
    endfunction

    // v / 10 as (v * 205) >> 11, exact for all 6-bit values
    function automatic logic [3:0] tens_of(input logic [VOLT_W-1:0] v);
        logic [13:0] prod;
        begin
            prod = 14'({8'd0, v} * 14'd205);
            return {1'b0, prod[13:11]};
        end
    endfunction

    function automatic logic [3:0] units_of(input logic [VOLT_W-1:0] v);
        logic [3:0]        t;
        logic [VOLT_W-1:0] tx10;
        begin
            t    = tens_of(v);
            tx10 = VOLT_W'({t, 3'b000} + {2'b00, t, 1'b0});
            return 4'(v - tx10);
        end
    endfunction

endpackage
`default_nettype wire

// ----- design/adc_average_voltage_display_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// adc_average_voltage_display_unit: averaging voltmeter with 2-digit display
// Sums converter samples, averages them per run, scales to tenths of a volt
// and drives a multiplexed two-digit 7-segment display.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one word: operation selects a
//   converter sample or a display refresh tick. Every word yields exactly one
//   output word (out_valid/out_ready) with the current segment pattern, digit
//   enable, stored voltage and a run_done flag.
//   Config channel (cfg_valid/cfg_ready) writes sample_count_minus_one; it is
//   taken only while the block is idle.
// Flow:
//   Ticks and samples that do not close a run go from accept through the
//   write state to the output register; input is ready again once the
//   output register is loaded. A sample that closes a run does two passes
//   through the shared serial divider (average, then scaling by full
//   scale). One word is in flight at a time.
// Reset: sum, counters, voltage and display drive clear; low digit first;
//   sample count returns to 8 (sample_count_minus_one = 7).
// Stall: a finished word waits in the output register; one more input word
//   may be taken and processed, then the block holds until the output frees.
// ----------------------------------------------------------------------------
module adc_average_voltage_display_unit
    import aavd_pkg::*;
#(
    parameter int SAMPLE_BITS = 10
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic                   operation,
    input  wire logic [SAMPLE_BITS-1:0] sample,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic      [SEG_W-1:0]       segments,
    output logic      [EN_W-1:0]        digit_enable,
    output logic      [VOLT_W-1:0]      voltage_tenths,
    output logic                        run_done,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CNT_W-1:0]       sample_count_minus_one
);

    localparam int SUM_W = SAMPLE_BITS + 4;
    localparam int SCL_W = SAMPLE_BITS + 10;
    localparam logic [SAMPLE_BITS-1:0] FULL_SCALE = '1;
    localparam logic [SAMPLE_BITS-1:0] HALF_SCALE = FULL_SCALE >> 1;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_DIV1  = 2'd1;
    localparam logic [1:0] ST_DIV2  = 2'd2;
    localparam logic [1:0] ST_WRITE = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [CNT_W-1:0]  taken_reg, taken_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [VOLT_W-1:0] volt_reg, volt_next;
    logic              done_flag_reg, done_flag_next;

    logic              out_valid_reg;
    logic [SEG_W-1:0]  seg_out_reg;
    logic [EN_W-1:0]   en_out_reg;
    logic [VOLT_W-1:0] volt_out_reg;
    logic              run_done_reg;
    logic              load_out;

    logic [SUM_W-1:0]       sum_add;
    logic [SUM_W-1:0]       avg;
    logic                   div_start;
    logic [SCL_W-1:0]       div_dvd;
    logic [SAMPLE_BITS-1:0] div_dvs;
    logic [SCL_W-1:0]       div_quot;
    div_status_t            div_status;

    logic              in_accept;
    logic              disp_tick;
    logic [SEG_W-1:0]  disp_seg;
    logic [EN_W-1:0]   disp_en;

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE);
    assign in_accept = in_valid && in_ready;
    assign disp_tick = in_accept && (operation == OP_TICK);

    assign sum_add = SUM_W'(sum_reg + SUM_W'(sample));
    assign avg     = div_quot[SUM_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        sum_next       = sum_reg;
        taken_next     = taken_reg;
        volt_next      = volt_reg;
        done_flag_next = done_flag_reg;
        div_start      = 1'b0;
        div_dvd        = '0;
        div_dvs        = '0;
        load_out       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    done_flag_next = 1'b0;
                    state_next     = ST_WRITE;
                    if (operation == OP_SAMPLE)
                    begin
                        if (taken_reg >= cnt_reg)
                        begin
                            div_start      = 1'b1;
                            div_dvd        = SCL_W'(sum_add);
                            div_dvs        = SAMPLE_BITS'({1'b0, cnt_reg} + 5'd1);
                            sum_next       = '0;
                            taken_next     = '0;
                            done_flag_next = 1'b1;
                            state_next     = ST_DIV1;
                        end
                        else
                        begin
                            sum_next   = sum_add;
                            taken_next = taken_reg + 1'b1;
                        end
                    end
                end
            end
            ST_DIV1:
            begin
                // average ready: scale by 33/full-scale with rounding offset
                if (div_status.done)
                begin
                    div_start  = 1'b1;
                    div_dvd    = SCL_W'({avg, 5'b00000}) + SCL_W'(avg)
                                 + SCL_W'(HALF_SCALE);
                    div_dvs    = FULL_SCALE;
                    state_next = ST_DIV2;
                end
            end
            ST_DIV2:
            begin
                if (div_status.done)
                begin
                    volt_next  = div_quot[VOLT_W-1:0];
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sum_reg       <= '0;
            taken_reg     <= '0;
            cnt_reg       <= CNT_RESET;
            volt_reg      <= '0;
            done_flag_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            seg_out_reg   <= '0;
            en_out_reg    <= EN_NONE;
            volt_out_reg  <= '0;
            run_done_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            taken_reg     <= taken_next;
            volt_reg      <= volt_next;
            done_flag_reg <= done_flag_next;
            if (cfg_valid && cfg_ready)
            begin
                cnt_reg <= sample_count_minus_one;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
                seg_out_reg   <= disp_seg;
                en_out_reg    <= disp_en;
                volt_out_reg  <= volt_reg;
                run_done_reg  <= done_flag_reg;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    aavd_serdiv #(
        .DVD_W      (SCL_W),
        .DVS_W      (SAMPLE_BITS),
        .DIGIT_BITS (2)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .quotient (div_quot),
        .status   (div_status)
    );

    aavd_disp u_disp (
        .clk      (clk),
        .rst_n    (rst_n),
        .tick     (disp_tick),
        .voltage  (volt_reg),
        .segments (disp_seg),
        .enable   (disp_en)
    );

    assign out_valid      = out_valid_reg;
    assign segments       = seg_out_reg;
    assign digit_enable   = en_out_reg;
    assign voltage_tenths = volt_out_reg;
    assign run_done       = run_done_reg;

    a_enable_onehot0: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(digit_enable))
        else $error("digit enable has more than one digit on");

    a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_status.busy)
        else $error("divider started while busy");

    a_done_in_div_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_status.done |-> (state_reg == ST_DIV1 || state_reg == ST_DIV2))
        else $error("divider finished outside a divide state");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg != ST_IDLE))
        else $error("accepted word did not leave idle");

endmodule
`default_nettype wire

// ----- design/aavd_serdiv.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// aavd_serdiv: digit-serial restoring divider
// Retires DIGIT_BITS quotient bits per cycle; dividend and quotient share
// one shift register, the partial remainder stays divisor-wide.
// ----------------------------------------------------------------------------
module aavd_serdiv
    import aavd_pkg::*;
#(
    parameter int DVD_W      = 20,
    parameter int DVS_W      = 10,
    parameter int DIGIT_BITS = 2
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [DVD_W-1:0] dividend,
    input  wire logic [DVS_W-1:0] divisor,
    output logic      [DVD_W-1:0] quotient,
    output div_status_t           status
);

    localparam int STEPS = (DVD_W + DIGIT_BITS - 1) / DIGIT_BITS;
    localparam int PAD_W = STEPS * DIGIT_BITS;
    localparam int STP_W = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam logic [STP_W-1:0] LAST_STEP = STP_W'(STEPS - 1);

    logic [PAD_W-1:0] work_reg, work_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg;
    logic [STP_W-1:0] step_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DVS_W:0]   trial;

    always_comb
    begin
        rem_next  = rem_reg;
        work_next = work_reg;
        trial     = '0;
        for (int i = 0; i < DIGIT_BITS; i++)
        begin
            trial     = {rem_next, work_next[PAD_W-1]};
            work_next = {work_next[PAD_W-2:0], 1'b0};
            if (trial >= {1'b0, dvs_reg})
            begin
                trial        = trial - {1'b0, dvs_reg};
                work_next[0] = 1'b1;
            end
            rem_next = trial[DVS_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            work_reg <= '0;
            rem_reg  <= '0;
            dvs_reg  <= '0;
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start && !busy_reg)
            begin
                work_reg <= PAD_W'(dividend);
                rem_reg  <= '0;
                dvs_reg  <= divisor;
                step_reg <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                work_reg <= work_next;
                rem_reg  <= rem_next;
                step_reg <= step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quotient    = work_reg[DVD_W-1:0];
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule
`default_nettype wire

// ----- design/aavd_disp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// aavd_disp: two-digit multiplexed 7-segment drive
// Each refresh tick shows the next digit of the stored value, low first.
// ----------------------------------------------------------------------------
module aavd_disp
    import aavd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              tick,
    input  wire logic [VOLT_W-1:0] voltage,
    output logic      [SEG_W-1:0]  segments,
    output logic      [EN_W-1:0]   enable
);

    logic             show_high_reg;
    logic [SEG_W-1:0] seg_reg;
    logic [EN_W-1:0]  en_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            show_high_reg <= 1'b0;
            seg_reg       <= '0;
            en_reg        <= EN_NONE;
        end
        else if (tick)
        begin
            show_high_reg <= ~show_high_reg;
            if (show_high_reg)
            begin
                en_reg  <= EN_HIGH;
                seg_reg <= seg_lookup(tens_of(voltage));
            end
            else
            begin
                en_reg  <= EN_LOW;
                seg_reg <= seg_lookup(units_of(voltage));
            end
        end
    end

    assign segments = seg_reg;
    assign enable   = en_reg;

endmodule
`default_nettype wire
